FILE: hw/rtl/cluster_box_stats_classifier_top_assert.svh
// Assertion macros for the cluster box statistics classifier.
`ifndef CLUSTER_BOX_STATS_CLASSIFIER_TOP_ASSERT_SVH
`define CLUSTER_BOX_STATS_CLASSIFIER_TOP_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define CBSC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, checked outside reset.
`define CBSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cbsc_pkg.sv
// Shared types and constants of the cluster box statistics classifier.
`default_nettype none
package cbsc_pkg;

  localparam int CW      = 19;  // coordinate width
  localparam int NW      = 12;  // point count width
  localparam int SW      = 31;  // coordinate sum width
  localparam int NUMW    = 16;  // cluster number width
  localparam int STEPW   = 5;   // divider step counter width
  localparam int MAX_PTS = 2048;
  localparam int IDXW    = 3;

  localparam logic [IDXW-1:0] REG_MIN_POINT_COUNT = 3'd0;
  localparam logic [IDXW-1:0] REG_MIN_HEIGHT      = 3'd1;
  localparam logic [IDXW-1:0] REG_MAX_HEIGHT      = 3'd2;
  localparam logic [IDXW-1:0] REG_MIN_WIDTH       = 3'd3;
  localparam logic [IDXW-1:0] REG_MAX_WIDTH       = 3'd4;
  localparam logic [IDXW-1:0] REG_MIN_LENGTH      = 3'd5;
  localparam logic [IDXW-1:0] REG_MAX_LENGTH      = 3'd6;

  localparam logic [NW-1:0] RST_MIN_POINT_COUNT = 12'd10;
  localparam logic [CW-1:0] RST_MIN_HEIGHT      = 19'd100;
  localparam logic [CW-1:0] RST_MAX_HEIGHT      = 19'd3000;
  localparam logic [CW-1:0] RST_MIN_WIDTH       = 19'd300;
  localparam logic [CW-1:0] RST_MAX_WIDTH       = 19'd8000;
  localparam logic [CW-1:0] RST_MIN_LENGTH      = 19'd200;
  localparam logic [CW-1:0] RST_MAX_LENGTH      = 19'd4000;

  typedef struct packed {
    logic acc_en;    // take the input word
    logic close;     // snapshot the closing cluster and start the divider
    logic div_step;  // advance the divider one bit
    logic load_out;  // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic close_req;  // input word closes a cluster that holds points
    logic div_done;   // divider is on its final bit
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cluster_box_stats_classifier_top.sv
// A word that closes a non-empty cluster has its result presented after the snapshot on the
// edge that takes it, 31 restoring-divide steps of the three per-axis dividers and the output
// load; the result can be taken at the next edge after that.
// Throughput: one word per cycle while a cluster accumulates; a word that closes a non-empty
// cluster stalls the input through the divide and until the output register takes the result.
// Reset (rst, synchronous): thresholds return to defaults, accumulators clear,
// the cluster number returns to zero and the output register empties.
`default_nettype none
`include "cluster_box_stats_classifier_top_assert.svh"
module cluster_box_stats_classifier_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input words: at most one point each
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_x,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_y,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_z,
  input  wire logic                          point_valid,
  input  wire logic                          cluster_last,
  // result words: one per non-empty cluster
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cbsc_pkg::NUMW-1:0]          cluster_number,
  output logic [cbsc_pkg::NW-1:0]            point_count,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_x,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_y,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_z,
  output logic signed [cbsc_pkg::CW-1:0]     corner_x,
  output logic signed [cbsc_pkg::CW-1:0]     corner_y,
  output logic signed [cbsc_pkg::CW-1:0]     corner_z,
  output logic [cbsc_pkg::CW-1:0]            extent_x,
  output logic [cbsc_pkg::CW-1:0]            extent_y,
  output logic [cbsc_pkg::CW-1:0]            extent_z,
  output logic                               is_vehicle,
  // threshold register writes
  input  wire logic                          cfg_we,
  input  wire logic [cbsc_pkg::IDXW-1:0]     cfg_index,
  input  wire logic [cbsc_pkg::CW-1:0]       cfg_data
);

  cbsc_pkg::cmd_t  cmd;
  cbsc_pkg::stat_t stat;

  // Sequence accumulation, the divide and the hand-off into the output register.
  cbsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold thresholds, running sums and bounds, the divider and the result word.
  cbsc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .point_valid    (point_valid),
    .cluster_last   (cluster_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cluster_number (cluster_number),
    .point_count    (point_count),
    .centroid_x     (centroid_x),
    .centroid_y     (centroid_y),
    .centroid_z     (centroid_z),
    .corner_x       (corner_x),
    .corner_y       (corner_y),
    .corner_z       (corner_z),
    .extent_x       (extent_x),
    .extent_y       (extent_y),
    .extent_z       (extent_z),
    .is_vehicle     (is_vehicle)
  );

  // A started divide blocks new input words.
  `CBSC_ASSERT_NEXT(a_close_stalls, cmd.close, in_stall, "input not stalled during divide")
  // Loading a result always presents it.
  `CBSC_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded result not presented")
  // Empty clusters never produce a result word.
  `CBSC_ASSERT_SAME(a_no_empty, out_valid, point_count != '0, "result with zero points")

endmodule
`default_nettype wire

FILE: hw/rtl/cbsc_ctrl.sv
// Controller of the cluster box statistics classifier.
`default_nettype none
module cbsc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire cbsc_pkg::stat_t stat,
  output cbsc_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  always_comb begin
    out_free     = !out_valid || !out_stall;
    in_stall     = (state != ST_RUN);
    cmd.acc_en   = in_valid && (state == ST_RUN);
    cmd.close    = cmd.acc_en && stat.close_req;
    cmd.div_step = (state == ST_DIV);
    cmd.load_out = (state == ST_HOLD) && out_free;
    state_next   = state;
    case (state)
      ST_RUN: begin
        if (cmd.close) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cbsc_dp.sv
// Datapath of the cluster box statistics classifier: accumulators, divider, result.
`default_nettype none
module cbsc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cbsc_pkg::cmd_t                cmd,
  output cbsc_pkg::stat_t                    stat,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_x,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_y,
  input  wire logic [cbsc_pkg::CW-1:0]       pos_z,
  input  wire logic                          point_valid,
  input  wire logic                          cluster_last,
  input  wire logic                          cfg_we,
  input  wire logic [cbsc_pkg::IDXW-1:0]     cfg_index,
  input  wire logic [cbsc_pkg::CW-1:0]       cfg_data,
  output logic [cbsc_pkg::NUMW-1:0]          cluster_number,
  output logic [cbsc_pkg::NW-1:0]            point_count,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_x,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_y,
  output logic signed [cbsc_pkg::CW-1:0]     centroid_z,
  output logic signed [cbsc_pkg::CW-1:0]     corner_x,
  output logic signed [cbsc_pkg::CW-1:0]     corner_y,
  output logic signed [cbsc_pkg::CW-1:0]     corner_z,
  output logic [cbsc_pkg::CW-1:0]            extent_x,
  output logic [cbsc_pkg::CW-1:0]            extent_y,
  output logic [cbsc_pkg::CW-1:0]            extent_z,
  output logic                               is_vehicle
);

  localparam int CW = cbsc_pkg::CW;
  localparam int NW = cbsc_pkg::NW;
  localparam int SW = cbsc_pkg::SW;

  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // thresholds
  logic [NW-1:0] min_pts;
  logic [CW-1:0] min_h, max_h, min_w, max_w, min_l, max_l;

  // running cluster state
  logic [2:0][SW-1:0] sum;
  logic [2:0][CW-1:0] low;
  logic [2:0][CW-1:0] high;
  logic [NW-1:0]      count;
  logic [cbsc_pkg::NUMW-1:0] counter;

  logic [2:0][CW-1:0] pt;
  logic [2:0][SW-1:0] sum_next;
  logic [2:0][CW-1:0] low_next;
  logic [2:0][CW-1:0] high_next;
  logic [NW-1:0]      count_next;
  logic               take;

  // closed cluster snapshot and divider
  logic [cbsc_pkg::NUMW-1:0] snap_num;
  logic [NW-1:0]             snap_cnt;
  logic [2:0]                snap_neg;
  logic [2:0][CW-1:0]        snap_low;
  logic [2:0][CW-1:0]        snap_high;
  logic [2:0][SW-1:0]        dvd;
  logic [2:0][NW-1:0]        rem;
  logic [cbsc_pkg::STEPW-1:0] step;

  logic [2:0][NW:0]   shifted;
  logic [2:0][NW:0]   trial;
  logic [2:0][SW-1:0] quo;
  logic [2:0][CW-1:0] ext;
  logic               veh;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pts <= cbsc_pkg::RST_MIN_POINT_COUNT;
      min_h   <= cbsc_pkg::RST_MIN_HEIGHT;
      max_h   <= cbsc_pkg::RST_MAX_HEIGHT;
      min_w   <= cbsc_pkg::RST_MIN_WIDTH;
      max_w   <= cbsc_pkg::RST_MAX_WIDTH;
      min_l   <= cbsc_pkg::RST_MIN_LENGTH;
      max_l   <= cbsc_pkg::RST_MAX_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        cbsc_pkg::REG_MIN_POINT_COUNT: min_pts <= cfg_data[NW-1:0];
        cbsc_pkg::REG_MIN_HEIGHT:      min_h   <= cfg_data;
        cbsc_pkg::REG_MAX_HEIGHT:      max_h   <= cfg_data;
        cbsc_pkg::REG_MIN_WIDTH:       min_w   <= cfg_data;
        cbsc_pkg::REG_MAX_WIDTH:       max_w   <= cfg_data;
        cbsc_pkg::REG_MIN_LENGTH:      min_l   <= cfg_data;
        cbsc_pkg::REG_MAX_LENGTH:      max_l   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pt[0] = pos_x;
    pt[1] = pos_y;
    pt[2] = pos_z;
    take       = point_valid && (count < NW'(cbsc_pkg::MAX_PTS));
    count_next = count + NW'(take);
    for (int i = 0; i < 3; i++) begin
      sum_next[i]  = sum[i];
      low_next[i]  = low[i];
      high_next[i] = high[i];
      if (take) begin
        sum_next[i] = sum[i] + {{(SW-CW){pt[i][CW-1]}}, pt[i]};
        if ($signed(pt[i]) < $signed(low[i]))  low_next[i]  = pt[i];
        if ($signed(pt[i]) > $signed(high[i])) high_next[i] = pt[i];
      end
    end
    stat.close_req = cluster_last && (count_next != '0);
    stat.div_done  = (step == cbsc_pkg::STEPW'(SW-1));

    for (int i = 0; i < 3; i++) begin
      shifted[i] = {rem[i], dvd[i][SW-1]};
      trial[i]   = shifted[i] - {1'b0, snap_cnt};
      quo[i]     = snap_neg[i] ? (SW'(0) - dvd[i]) : dvd[i];
      ext[i]     = snap_high[i] - snap_low[i];
    end
    veh = (snap_cnt >= min_pts) &&
          (ext[2] >= min_h) && (ext[2] <= max_h) &&
          (ext[0] >= min_w) && (ext[0] <= max_w) &&
          (ext[1] >= min_l) && (ext[1] <= max_l);
  end

  // accumulate; clear on the closing word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum[i]  <= '0;
        low[i]  <= COORD_MAX;
        high[i] <= COORD_MIN;
      end
      count   <= '0;
      counter <= '0;
      step    <= '0;
    end else begin
      if (cmd.acc_en) begin
        if (cluster_last) begin
          for (int i = 0; i < 3; i++) begin
            sum[i]  <= '0;
            low[i]  <= COORD_MAX;
            high[i] <= COORD_MIN;
          end
          count   <= '0;
          counter <= counter + 1'b1;
        end else begin
          sum   <= sum_next;
          low   <= low_next;
          high  <= high_next;
          count <= count_next;
        end
      end
      if (cmd.close) step <= '0;
      else if (cmd.div_step) step <= step + 1'b1;
    end
  end

  // snapshot and one quotient bit per axis per cycle
  always_ff @(posedge clk) begin
    if (cmd.close) begin
      snap_num  <= counter;
      snap_cnt  <= count_next;
      snap_low  <= low_next;
      snap_high <= high_next;
      for (int i = 0; i < 3; i++) begin
        snap_neg[i] <= sum_next[i][SW-1];
        dvd[i]      <= sum_next[i][SW-1] ? (SW'(0) - sum_next[i]) : sum_next[i];
        rem[i]      <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (!trial[i][NW]) begin
          rem[i] <= trial[i][NW-1:0];
          dvd[i] <= {dvd[i][SW-2:0], 1'b1};
        end else begin
          rem[i] <= shifted[i][NW-1:0];
          dvd[i] <= {dvd[i][SW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cluster_number <= snap_num;
      point_count    <= snap_cnt;
      centroid_x     <= quo[0][CW-1:0];
      centroid_y     <= quo[1][CW-1:0];
      centroid_z     <= quo[2][CW-1:0];
      corner_x       <= snap_low[0];
      corner_y       <= snap_low[1];
      corner_z       <= snap_low[2];
      extent_x       <= ext[0];
      extent_y       <= ext[1];
      extent_z       <= ext[2];
      is_vehicle     <= veh;
    end
  end

endmodule
`default_nettype wire
